[hdl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, sizes and command codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = PAGE_W + 1;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = 13;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PAGES);

  // Read address selects for the page memories.
  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_BLK  = 3'd1;
  localparam logic [2:0] RD_HALF = 3'd2;
  localparam logic [2:0] RD_PG   = 3'd3;
  localparam logic [2:0] RD_BUD  = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  block_order;
    logic [11:0] page_index;
  } bpa_in_t;

  typedef struct packed {
    logic        status;
    logic [11:0] granted_page;
    logic [12:0] total_free_pages;
  } bpa_out_t;

  typedef struct packed {
    logic [2:0] rd_sel;
    logic       load;
    logic       cur_inc;
    logic       set_fail;
    logic       unlink;
    logic       set_grant;
    logic       sub_total;
    logic       add_total;
    logic       merge_step;
    logic       push1;
    logic       push2;
    logic       clr;
    logic       out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic head_valid;
    logic cur_last;
    logic split_more;
    logic free_ok;
    logic merge_try;
    logic merge_hit;
    logic rd_head;
  } bpa_stat_t;

endpackage

[hdl/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// bpa_datapath
// Page memories, free list heads, counters and the result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  bpa_cmd_t         cmd,
  input  bpa_in_t          in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output bpa_stat_t        stat,
  output bpa_out_t         out_data
);

  // Per page: head mark on top, block order below.
  logic [ORD_W:0]    info_mem [NUM_PAGES];
  logic [LINK_W-1:0] next_mem [NUM_PAGES];
  logic [LINK_W-1:0] prev_mem [NUM_PAGES];
  logic [ORD_W:0]    rd_info;
  logic [LINK_W-1:0] rd_next;
  logic [LINK_W-1:0] rd_prev;

  logic [LINK_W-1:0] order_head [NUM_ORDERS];
  logic [ORD_W-1:0]  req_ord;
  logic [ORD_W-1:0]  cur;
  logic [PAGE_W-1:0] blk;
  logic [PAGE_W-1:0] u;
  logic              is_free;
  logic              fail;
  logic [PAGE_W-1:0] granted;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  present;
  logic [LINK_W-1:0] h_saved;
  logic [PAGE_W-1:0] clr_cnt;

  logic [ORD_W-1:0]  cur_dn;
  logic              cur_ok;
  logic [LINK_W-1:0] lh_cur;
  logic [PAGE_W-1:0] half;
  logic [PAGE_W-1:0] bud;
  logic [PAGE_W-1:0] rd_addr;
  logic [PAGE_W-1:0] p_pg;
  logic [CNT_W:0]    size_cur;
  logic [CNT_W:0]    size_req;
  logic [CNT_W:0]    add_sum;
  logic              p_ok;
  logic              n_ok;
  logic [ORD_W-1:0]  u_ord;

  logic              info_we;
  logic [PAGE_W-1:0] info_addr;
  logic [ORD_W:0]    info_wdata;
  logic              next_we;
  logic [PAGE_W-1:0] next_addr;
  logic [LINK_W-1:0] next_wdata;
  logic              prev_we;
  logic [PAGE_W-1:0] prev_addr;
  logic [LINK_W-1:0] prev_wdata;

  always_comb begin
    cur_dn   = cur - ORD_W'(1);
    cur_ok   = cur < ORD_W'(NUM_ORDERS);
    lh_cur   = cur_ok ? order_head[cur] : NIL_LINK;
    half     = blk + (PAGE_W'(1) << cur_dn);
    bud      = blk ^ (PAGE_W'(1) << cur);
    p_pg     = is_free ? blk : u;
    size_cur = (CNT_W+1)'(1) << cur;
    size_req = (CNT_W+1)'(1) << req_ord;
    add_sum  = {1'b0, total} + size_cur;
    p_ok     = rd_prev < NIL_LINK;
    n_ok     = rd_next < NIL_LINK;
    u_ord    = (rd_info[ORD_W-1:0] >= ORD_W'(NUM_ORDERS)) ? ORD_W'(NUM_ORDERS - 1)
                                                           : rd_info[ORD_W-1:0];
    case (cmd.rd_sel)
      RD_BLK:  rd_addr = lh_cur[PAGE_W-1:0];
      RD_HALF: rd_addr = half;
      RD_PG:   rd_addr = blk;
      RD_BUD:  rd_addr = bud;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    stat.clr_done   = &clr_cnt;
    stat.head_valid = lh_cur < NIL_LINK;
    stat.cur_last   = cur == ORD_W'(NUM_ORDERS - 1);
    stat.split_more = cur > req_ord;
    stat.free_ok    = cur_ok && !rd_info[ORD_W]
                      && (({1'b0, blk} & (size_cur[PAGE_W:0] - (PAGE_W+1)'(1))) == '0)
                      && ({2'b0, blk} + size_cur <= (CNT_W+1)'(NUM_PAGES));
    stat.merge_try  = (cur < ORD_W'(NUM_ORDERS - 1)) && ({1'b0, bud} < present);
    stat.merge_hit  = rd_info[ORD_W] && (rd_info[ORD_W-1:0] == cur);
    stat.rd_head    = rd_info[ORD_W];
  end

  // Write port selection; the controller never raises two writers at once.
  always_comb begin
    info_we    = 1'b0;
    info_addr  = u;
    info_wdata = '0;
    if (cmd.clr) begin
      info_we   = 1'b1;
      info_addr = clr_cnt;
    end else if (cmd.unlink) begin
      info_we   = 1'b1;
      info_addr = u;
    end else if (cmd.push1) begin
      info_we    = 1'b1;
      info_addr  = p_pg;
      info_wdata = {1'b1, cur};
    end

    next_we    = 1'b0;
    next_addr  = p_pg;
    next_wdata = lh_cur;
    if (cmd.unlink && p_ok) begin
      next_we    = 1'b1;
      next_addr  = rd_prev[PAGE_W-1:0];
      next_wdata = rd_next;
    end else if (cmd.push1) begin
      next_we = 1'b1;
    end

    prev_we    = 1'b0;
    prev_addr  = p_pg;
    prev_wdata = NIL_LINK;
    if (cmd.unlink && n_ok) begin
      prev_we    = 1'b1;
      prev_addr  = rd_next[PAGE_W-1:0];
      prev_wdata = rd_prev;
    end else if (cmd.push1) begin
      prev_we = 1'b1;
    end else if (cmd.push2 && (h_saved < NIL_LINK)) begin
      prev_we    = 1'b1;
      prev_addr  = h_saved[PAGE_W-1:0];
      prev_wdata = {1'b0, p_pg};
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_addr] <= info_wdata;
    end
    rd_info <= info_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    rd_next <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_addr] <= prev_wdata;
    end
    rd_prev <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= CNT_W'(NUM_PAGES);
      total   <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        order_head[i] <= NIL_LINK;
      end
    end else begin
      if (cfg_we) begin
        present <= cfg_data;
      end
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + PAGE_W'(1);
      end
      if (cmd.unlink && !p_ok) begin
        order_head[u_ord] <= n_ok ? rd_next : NIL_LINK;
      end else if (cmd.push1) begin
        order_head[cur] <= {1'b0, p_pg};
      end
      if (cmd.sub_total) begin
        total <= ({1'b0, total} > size_req) ? total - size_req[CNT_W-1:0] : '0;
      end else if (cmd.add_total) begin
        total <= add_sum[CNT_W] ? {CNT_W{1'b1}} : add_sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_ord <= in_data.block_order;
      cur     <= in_data.block_order;
      blk     <= in_data.page_index;
      is_free <= in_data.req_type;
      fail    <= !in_data.req_type && (in_data.block_order >= ORD_W'(NUM_ORDERS));
      granted <= '0;
    end
    if (cmd.cur_inc || cmd.merge_step) begin
      cur <= cur + ORD_W'(1);
    end else if (cmd.rd_sel == RD_HALF) begin
      cur <= cur_dn;
    end
    if (cmd.rd_sel == RD_BLK) begin
      u   <= lh_cur[PAGE_W-1:0];
      blk <= lh_cur[PAGE_W-1:0];
    end else if (cmd.rd_sel == RD_HALF) begin
      u <= half;
    end else if (cmd.rd_sel == RD_BUD) begin
      u <= bud;
    end
    if (cmd.merge_step) begin
      blk <= blk & u;
    end
    if (cmd.set_grant) begin
      granted <= blk;
    end
    if (cmd.set_fail) begin
      fail <= 1'b1;
    end
    if (cmd.push1) begin
      h_saved <= lh_cur;
    end
    if (cmd.out_load) begin
      out_data.status           <= fail;
      out_data.granted_page     <= granted;
      out_data.total_free_pages <= total;
    end
  end

endmodule

[hdl/bpa_controller.sv]
// ----------------------------------------------------------------------------
// bpa_controller
// Sequencer for clear, allocate search and split, free check and merge.
// ----------------------------------------------------------------------------
module bpa_controller import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  bpa_in_t   in_data,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_AUNL  = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_SCHK  = 4'd5;
  localparam logic [3:0] S_PUSH1 = 4'd6;
  localparam logic [3:0] S_PUSH2 = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_MRD   = 4'd10;
  localparam logic [3:0] S_MCHK  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       is_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_data.req_type) begin
            state_next = S_FRD;
          end else if (in_data.block_order >= 4'(NUM_ORDERS)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.head_valid) begin
          cmd.rd_sel = RD_BLK;
          state_next = S_AUNL;
        end else if (stat.cur_last) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.cur_inc = 1'b1;
        end
      end
      S_AUNL: begin
        cmd.unlink    = 1'b1;
        cmd.set_grant = 1'b1;
        cmd.sub_total = 1'b1;
        state_next    = S_SPLIT;
      end
      S_SPLIT: begin
        if (stat.split_more) begin
          cmd.rd_sel = RD_HALF;
          state_next = S_SCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCHK: begin
        // A half that already heads a free block leaves its old list first.
        cmd.unlink = stat.rd_head;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        cmd.push1  = 1'b1;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.push2  = 1'b1;
        state_next = is_free ? S_DONE : S_SPLIT;
      end
      S_FRD: begin
        cmd.rd_sel = RD_PG;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (stat.free_ok) begin
          cmd.add_total = 1'b1;
          state_next    = S_MRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MRD: begin
        if (stat.merge_try) begin
          cmd.rd_sel = RD_BUD;
          state_next = S_MCHK;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_MCHK: begin
        if (stat.merge_hit) begin
          cmd.unlink     = 1'b1;
          cmd.merge_step = 1'b1;
          state_next     = S_MRD;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
      is_free   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        is_free <= in_data.req_type;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over 4096 pages with LIFO free lists per order.
// ----------------------------------------------------------------------------
// Usage: each beat on the in channel is one request, allocate or free, and
// yields exactly one beat on the out channel with the status, the granted
// page and the free page total after the request. The cfg channel writes the
// present page count; the user is to write it only while the block is idle,
// which the block itself does not enforce, and cfg_ready is always high.
// After reset the block clears the head marks of all 4096 pages, one page a
// cycle, with in_ready low during that sweep. A request is worked on alone.
// Allocate is accepted, searches one order at a time, takes the block off
// its list, then per split level takes the upper half off any list it heads
// and pushes it, ends the split and loads the result. Free is accepted,
// reads and checks the page, reads and checks each buddy to merge, pushes
// the block and loads the result. The walk over the orders and the single
// read address of each page memory set these steps. The result sits in an
// output register; a stalled receiver holds it there, and the next request
// is accepted and worked on meanwhile, waiting only to load its own result.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpa_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bpa_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  assign cfg_ready = 1'b1;

  bpa_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[hdl/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bpa_out_t out_data
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A failed allocation never reports a page.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.granted_page == '0)
    else $error("failure carries a nonzero page");

  // One request at a time: an accepted beat closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request was taken");

  // The clearing sweep keeps the input closed just after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("input ready during the clearing sweep");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/buddy_page_allocator_test.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_test
// Self-checking bench for the buddy page allocator. Requests are driven on the
// in channel under random idle bursts, a behavioral copy of the free lists
// predicts each out beat, and the present page count is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_page_allocator_test;
  import bpa_pkg::*;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_NOBLK  = 1'b1;
  localparam int   NIL       = NUM_PAGES;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bpa_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bpa_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  buddy_page_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Behavioral copy of the allocator state.
  int unsigned model_present;
  bit          head_mark [NUM_PAGES];
  int unsigned page_ord  [NUM_PAGES];
  int unsigned nxt       [NUM_PAGES];
  int unsigned prv       [NUM_PAGES];
  int unsigned list_top  [NUM_ORDERS];
  int unsigned list_len  [NUM_ORDERS];
  int unsigned free_total;

  bpa_out_t pending_results [$];
  int       fail_count = 0;
  int       beats_checked = 0;
  int       allocs_granted = 0;
  int       merges_seen = 0;
  bit       in_calm = 1'b0;
  bit       out_calm = 1'b0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void list_push(input int unsigned o, input int unsigned p);
    int unsigned h;
    h = list_top[o];
    nxt[p] = h;
    prv[p] = NIL;
    if (h < NIL) prv[h] = p;
    list_top[o] = p;
    list_len[o] = (list_len[o] + 1) & 13'h1fff;
    head_mark[p] = 1'b1;
    page_ord[p] = o;
  endfunction

  function automatic void list_unlink(input int unsigned p);
    int unsigned o, pp, nn;
    o = page_ord[p];
    pp = prv[p];
    nn = nxt[p];
    if (o >= NUM_ORDERS) o = NUM_ORDERS - 1;
    if (pp < NIL) nxt[pp] = nn;
    else list_top[o] = (nn < NIL) ? nn : NIL;
    if (nn < NIL) prv[nn] = pp;
    list_len[o] = (list_len[o] - 1) & 13'h1fff;
    head_mark[p] = 1'b0;
    page_ord[p] = 0;
  endfunction

  function automatic void clear_pages();
    model_present = NUM_PAGES;
    for (int i = 0; i < NUM_PAGES; i++) begin
      head_mark[i] = 1'b0;
      page_ord[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int i = 0; i < NUM_ORDERS; i++) begin
      list_top[i] = NIL;
      list_len[i] = 0;
    end
    free_total = 0;
  endfunction

  function automatic bpa_out_t serve_request(input bpa_in_t rq);
    bpa_out_t    r;
    int unsigned o, cur, blk, sz, half, pg, bud;
    bit          found;
    r = '0;
    o = rq.block_order;
    pg = rq.page_index;
    if (rq.req_type == REQ_ALLOC) begin
      found = 1'b0;
      cur = o;
      if (o < NUM_ORDERS) begin
        for (cur = o; cur < NUM_ORDERS; cur++) begin
          if (list_top[cur] < NIL) begin
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) begin
        r.status = ST_NOBLK;
      end else begin
        blk = list_top[cur];
        sz = 1 << o;
        list_unlink(blk);
        free_total = (free_total > sz) ? free_total - sz : 0;
        while (cur > o) begin
          cur--;
          half = blk + (1 << cur);
          if (half < NUM_PAGES) begin
            if (head_mark[half]) list_unlink(half);
            list_push(cur, half);
          end
        end
        r.granted_page = blk[11:0];
        allocs_granted++;
      end
    end else if (o < NUM_ORDERS) begin
      sz = 1 << o;
      if ((pg & (sz - 1)) == 0 && pg + sz <= NUM_PAGES && !head_mark[pg]) begin
        free_total += sz;
        if (free_total > 8191) free_total = 8191;
        while (o < NUM_ORDERS - 1) begin
          bud = pg ^ (1 << o);
          if (bud >= model_present || bud >= NUM_PAGES) break;
          if (!head_mark[bud] || page_ord[bud] != o) break;
          list_unlink(bud);
          merges_seen++;
          pg = pg & bud;
          o++;
        end
        list_push(o, pg);
      end
    end
    r.total_free_pages = free_total[12:0];
    return r;
  endfunction

  // Out channel: random stall bursts, check every beat against the oldest one.
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    bpa_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("out beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (out_data.status !== want.status)
          report($sformatf("status %0b want %0b", out_data.status, want.status));
        if (out_data.granted_page !== want.granted_page)
          report($sformatf("granted_page %0d want %0d",
                           out_data.granted_page, want.granted_page));
        if (out_data.total_free_pages !== want.total_free_pages)
          report($sformatf("total_free_pages %0d want %0d",
                           out_data.total_free_pages, want.total_free_pages));
      end
    end
  end

  // Sends one request; the expectation is queued at the accepting edge.
  // The beat starts on a falling edge, now and then after a random idle burst.
  task automatic send_request(input logic rt, input int unsigned o,
                              input int unsigned p);
    bpa_in_t rq;
    rq.req_type = rt;
    rq.block_order = o[3:0];
    rq.page_index = p[11:0];
    @(negedge clk);
    if (!in_calm && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 16)) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(serve_request(rq));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // A directed row that carries its expectation checks it against the model's prediction once the beat is accepted.
  task automatic send_checked(input logic rt, input int unsigned o,
                              input int unsigned p, input logic st,
                              input int unsigned gp, input int unsigned tot);
    bpa_out_t last;
    send_request(rt, o, p);
    last = pending_results[$];
    if (last.status !== st || last.granted_page !== gp[11:0]
        || last.total_free_pages !== tot[12:0])
      report($sformatf("directed row rt=%0b o=%0d p=%0d", rt, o, p));
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_present(input int unsigned n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_present = n & 13'h1fff;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocate, free what was granted, free regions.
  task automatic random_phase(input int count);
    int unsigned held_pg [$];
    int unsigned held_ord [$];
    int unsigned o, p, k, sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        send_request(REQ_ALLOC, o, $urandom_range(0, 4095));
        if (pending_results[$].status == ST_DONE && o < NUM_ORDERS) begin
          held_pg.push_back(pending_results[$].granted_page);
          held_ord.push_back(o);
        end
      end else if (sel < 70 && held_pg.size() != 0) begin
        k = $urandom_range(0, held_pg.size() - 1);
        send_request(REQ_FREE, held_ord[k], held_pg[k]);
        held_pg.delete(k);
        held_ord.delete(k);
      end else if (sel < 90) begin
        o = $urandom_range(0, 10);
        p = ($urandom_range(0, 4095) >> o) << o;
        send_request(REQ_FREE, o, p);
      end else begin
        send_request(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                     $urandom_range(0, 4095));
      end
    end
  endtask

  typedef struct {
    logic        rt;
    int unsigned o;
    int unsigned p;
    bit          known;
    logic        st;
    int unsigned gp;
    int unsigned tot;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{REQ_ALLOC, 0,    0,    1, ST_NOBLK, 0, 0},     // empty after reset
    '{REQ_ALLOC, 10,   0,    1, ST_NOBLK, 0, 0},
    '{REQ_ALLOC, 15,   4095, 1, ST_NOBLK, 0, 0},     // order too large
    '{REQ_FREE,  15,   0,    1, ST_DONE,  0, 0},     // order too large, ignored
    '{REQ_FREE,  1,    1,    1, ST_DONE,  0, 0},     // misaligned
    '{REQ_FREE,  0,    4095, 1, ST_DONE,  0, 1},
    '{REQ_FREE,  0,    4095, 1, ST_DONE,  0, 1},     // double free
    '{REQ_FREE,  10,   0,    1, ST_DONE,  0, 1025},
    '{REQ_FREE,  10,   1024, 0, ST_DONE,  0, 0},     // order 10 is the top order, no merge
    '{REQ_ALLOC, 0,    0,    0, ST_DONE,  0, 0},     // taken from the order 0 list, no split
    '{REQ_FREE,  4,    16,   0, ST_DONE,  0, 0},     // overlapping free
    '{REQ_ALLOC, 3,    0,    0, ST_DONE,  0, 0},
    '{REQ_FREE,  0,    0,    0, ST_DONE,  0, 0},
    '{REQ_FREE,  10,   3072, 0, ST_DONE,  0, 0},
    '{REQ_FREE,  10,   2048, 0, ST_DONE,  0, 0},
    '{REQ_ALLOC, 10,   0,    0, ST_DONE,  0, 0},
    '{REQ_ALLOC, 10,   0,    0, ST_DONE,  0, 0},
    '{REQ_ALLOC, 10,   0,    0, ST_DONE,  0, 0},
    '{REQ_ALLOC, 2,    0,    0, ST_DONE,  0, 0},
    '{REQ_FREE,  0,    2048, 0, ST_DONE,  0, 0}
  };

  initial begin
    clear_pages();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].known)
        send_checked(directed_rows[i].rt, directed_rows[i].o, directed_rows[i].p,
                     directed_rows[i].st, directed_rows[i].gp, directed_rows[i].tot);
      else
        send_request(directed_rows[i].rt, directed_rows[i].o, directed_rows[i].p);
    end

    random_phase(250);
    write_present(0);
    random_phase(150);
    write_present(1536);
    random_phase(200);
    write_present(4095);
    random_phase(150);
    write_present(4096);
    in_calm = 1'b1;
    out_calm = 1'b1;
    random_phase(200);

    drain();
    $display("checked %0d result beats: %0d grants, %0d buddy merges,", beats_checked,
             allocs_granted, merges_seen);
    $display("present page count swept over 0, 1536, 4095 and 4096");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout covering the clear sweep, about 1000 requests and stall bursts,
  // taken many times over.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
